FILE: src/v3alu_pkg.sv
package v3alu_pkg;

    localparam logic [3:0] ACT_ADD       = 4'd0;
    localparam logic [3:0] ACT_SUB       = 4'd1;
    localparam logic [3:0] ACT_SCALE     = 4'd2;
    localparam logic [3:0] ACT_DOT       = 4'd3;
    localparam logic [3:0] ACT_CROSS     = 4'd4;
    localparam logic [3:0] ACT_NORM      = 4'd5;
    localparam logic [3:0] ACT_NORMALIZE = 4'd6;
    localparam logic [3:0] ACT_DIST      = 4'd7;
    localparam logic [3:0] ACT_EQUAL     = 4'd8;

    typedef struct packed {
        logic [3:0]         action;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic signed [31:0] scale;
    } item_t;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] scalar_out;
        logic               equal_flag;
        logic               null_error;
    } result_t;

    typedef struct packed {
        logic [3:0] action;
        logic       equal_flag;
        logic       null_error;
    } ctl_t;

endpackage

FILE: src/v3alu_front.sv
module v3alu_front #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  v3alu_pkg::item_t      in_data,
    output logic                  out_valid,
    output v3alu_pkg::ctl_t       out_ctl,
    output logic [3*W-1:0]        out_rv,
    output logic [W-1:0]          out_sv,
    output logic [2*W-1:0]        out_ssq,
    output logic [3*W-1:0]        out_aabs,
    output logic [2:0]            out_aneg
);

    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam int PW = 2*W + 2;

    function automatic logic signed [W-1:0] sat_add(input logic signed [W:0] v);
        logic signed [W-1:0] r;
        if (v[W] != v[W-1])
        begin
            r = v[W] ? WMIN : WMAX;
        end
        else
        begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [W-1:0] sat_prod(input logic signed [PW-1:0] v);
        logic signed [W-1:0] r;
        if (v > PW'(WMAX))
        begin
            r = WMAX;
        end
        else if (v < PW'(WMIN))
        begin
            r = WMIN;
        end
        else
        begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    logic signed [W-1:0] a [3];
    logic signed [W-1:0] b [3];
    logic signed [W-1:0] sc;
    logic signed [W-1:0] sum_w [3];
    logic signed [W-1:0] dif_w [3];
    logic                eq_w;

    logic signed [W-1:0] ma_next [6];
    logic signed [W-1:0] mb_next [6];
    logic signed [W-1:0] rv1_next [3];
    v3alu_pkg::ctl_t     ctl1_next;

    logic                s1_valid_reg;
    v3alu_pkg::ctl_t     s1_ctl_reg;
    logic signed [W-1:0] s1_rv_reg [3];
    logic signed [W-1:0] s1_ma_reg [6];
    logic signed [W-1:0] s1_mb_reg [6];
    logic signed [W-1:0] s1_a_reg [3];

    logic signed [2*W-1:0] p_next [6];
    logic                  s2_valid_reg;
    v3alu_pkg::ctl_t       s2_ctl_reg;
    logic signed [W-1:0]   s2_rv_reg [3];
    logic signed [2*W-1:0] s2_p_reg [6];
    logic signed [W-1:0]   s2_a_reg [3];

    logic signed [PW-1:0] sum3;
    logic signed [PW-1:0] cr [3];
    logic signed [PW-1:0] pe [3];
    logic signed [W-1:0]  rv3_next [3];
    logic signed [W-1:0]  sv3_next;
    logic [W-1:0]         aabs3_next [3];
    logic [2:0]           aneg3_next;

    logic                s3_valid_reg;
    v3alu_pkg::ctl_t     s3_ctl_reg;
    logic signed [W-1:0] s3_rv_reg [3];
    logic signed [W-1:0] s3_sv_reg;
    logic [2*W-1:0]      s3_ssq_reg;
    logic [W-1:0]        s3_aabs_reg [3];
    logic [2:0]          s3_aneg_reg;

    assign a[0] = in_data.ax[W-1:0];
    assign a[1] = in_data.ay[W-1:0];
    assign a[2] = in_data.az[W-1:0];
    assign b[0] = in_data.bx[W-1:0];
    assign b[1] = in_data.by[W-1:0];
    assign b[2] = in_data.bz[W-1:0];
    assign sc   = in_data.scale[W-1:0];

    assign eq_w = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_w[i] = sat_add((W+1)'(a[i]) + (W+1)'(b[i]));
            dif_w[i] = sat_add((W+1)'(a[i]) - (W+1)'(b[i]));
        end
    end

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            ma_next[i] = '0;
            mb_next[i] = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            rv1_next[i] = '0;
        end
        case (in_data.action)
            v3alu_pkg::ACT_ADD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rv1_next[i] = sum_w[i];
                end
            end
            v3alu_pkg::ACT_SUB:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rv1_next[i] = dif_w[i];
                end
            end
            v3alu_pkg::ACT_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma_next[i] = a[i];
                    mb_next[i] = sc;
                end
            end
            v3alu_pkg::ACT_DOT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma_next[i] = a[i];
                    mb_next[i] = b[i];
                end
            end
            v3alu_pkg::ACT_CROSS:
            begin
                ma_next[0] = a[1];
                mb_next[0] = b[2];
                ma_next[1] = a[2];
                mb_next[1] = b[1];
                ma_next[2] = a[2];
                mb_next[2] = b[0];
                ma_next[3] = a[0];
                mb_next[3] = b[2];
                ma_next[4] = a[0];
                mb_next[4] = b[1];
                ma_next[5] = a[1];
                mb_next[5] = b[0];
            end
            v3alu_pkg::ACT_NORM, v3alu_pkg::ACT_NORMALIZE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma_next[i] = a[i];
                    mb_next[i] = a[i];
                end
            end
            v3alu_pkg::ACT_DIST:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma_next[i] = dif_w[i];
                    mb_next[i] = dif_w[i];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        ctl1_next.action     = in_data.action;
        ctl1_next.equal_flag = (in_data.action == v3alu_pkg::ACT_EQUAL) && eq_w;
        ctl1_next.null_error = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ctl_reg <= ctl1_next;
            for (int i = 0; i < 3; i++)
            begin
                s1_rv_reg[i] <= rv1_next[i];
                s1_a_reg[i]  <= a[i];
            end
            for (int i = 0; i < 6; i++)
            begin
                s1_ma_reg[i] <= ma_next[i];
                s1_mb_reg[i] <= mb_next[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            p_next[i] = (2*W)'(s1_ma_reg[i]) * (2*W)'(s1_mb_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_ctl_reg <= s1_ctl_reg;
            for (int i = 0; i < 3; i++)
            begin
                s2_rv_reg[i] <= s1_rv_reg[i];
                s2_a_reg[i]  <= s1_a_reg[i];
            end
            for (int i = 0; i < 6; i++)
            begin
                s2_p_reg[i] <= p_next[i];
            end
        end
    end

    always_comb
    begin
        sum3 = PW'(s2_p_reg[0]) + PW'(s2_p_reg[1]) + PW'(s2_p_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            cr[i] = PW'(s2_p_reg[2*i]) - PW'(s2_p_reg[2*i+1]);
            pe[i] = PW'(s2_p_reg[i]);
            rv3_next[i] = s2_rv_reg[i];
            aneg3_next[i] = s2_a_reg[i][W-1];
            aabs3_next[i] = s2_a_reg[i][W-1] ? W'(-s2_a_reg[i]) : W'(s2_a_reg[i]);
        end
        sv3_next = '0;
        case (s2_ctl_reg.action)
            v3alu_pkg::ACT_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rv3_next[i] = sat_prod(pe[i] >>> F);
                end
            end
            v3alu_pkg::ACT_DOT:
            begin
                sv3_next = sat_prod(sum3 >>> F);
            end
            v3alu_pkg::ACT_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rv3_next[i] = sat_prod(cr[i] >>> F);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_ctl_reg  <= s2_ctl_reg;
            s3_sv_reg   <= sv3_next;
            s3_ssq_reg  <= sum3[2*W-1:0];
            s3_aneg_reg <= aneg3_next;
            for (int i = 0; i < 3; i++)
            begin
                s3_rv_reg[i]   <= rv3_next[i];
                s3_aabs_reg[i] <= aabs3_next[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            out_rv[i*W +: W]   = s3_rv_reg[i];
            out_aabs[i*W +: W] = s3_aabs_reg[i];
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_ctl   = s3_ctl_reg;
    assign out_sv    = s3_sv_reg;
    assign out_ssq   = s3_ssq_reg;
    assign out_aneg  = s3_aneg_reg;

endmodule

FILE: src/v3alu_sqrt_step.sv
module v3alu_sqrt_step #(
    parameter int W  = 32,
    parameter int CW = 227
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  v3alu_pkg::ctl_t   in_ctl,
    input  logic [CW-1:0]     in_carry,
    input  logic [2*W-1:0]    in_s,
    input  logic [W:0]        in_rem,
    input  logic [W-1:0]      in_root,
    output logic              out_valid,
    output v3alu_pkg::ctl_t   out_ctl,
    output logic [CW-1:0]     out_carry,
    output logic [2*W-1:0]    out_s,
    output logic [W:0]        out_rem,
    output logic [W-1:0]      out_root
);

    logic [W+1:0] cand;
    logic [W+1:0] trial;
    logic         ge;
    logic [W:0]   rem_next;

    logic            valid_reg;
    v3alu_pkg::ctl_t ctl_reg;
    logic [CW-1:0]   carry_reg;
    logic [2*W-1:0]  s_reg;
    logic [W:0]      rem_reg;
    logic [W-1:0]    root_reg;

    assign cand     = {in_rem[W-1:0], in_s[2*W-1 -: 2]};
    assign trial    = {in_root, 2'b01};
    assign ge       = (cand >= trial);
    assign rem_next = ge ? (W+1)'(cand - trial) : (W+1)'(cand);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg   <= in_ctl;
            carry_reg <= in_carry;
            s_reg     <= {in_s[2*W-3:0], 2'b00};
            rem_reg   <= rem_next;
            root_reg  <= {in_root[W-2:0], ge};
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_carry = carry_reg;
    assign out_s     = s_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule

FILE: src/v3alu_div_step.sv
module v3alu_div_step #(
    parameter int W  = 32,
    parameter int Q  = 17,
    parameter int CW = 131
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  v3alu_pkg::ctl_t   in_ctl,
    input  logic [CW-1:0]     in_carry,
    input  logic [W-1:0]      in_n,
    input  logic [3*(W+1)-1:0] in_r,
    input  logic [3*Q-1:0]    in_q,
    output logic              out_valid,
    output v3alu_pkg::ctl_t   out_ctl,
    output logic [CW-1:0]     out_carry,
    output logic [W-1:0]      out_n,
    output logic [3*(W+1)-1:0] out_r,
    output logic [3*Q-1:0]    out_q
);

    logic [W:0]           r_in [3];
    logic [W:0]           r_dif [3];
    logic                 ge [3];
    logic [3*(W+1)-1:0]   r_next;
    logic [3*Q-1:0]       q_next;

    logic                 valid_reg;
    v3alu_pkg::ctl_t      ctl_reg;
    logic [CW-1:0]        carry_reg;
    logic [W-1:0]         n_reg;
    logic [3*(W+1)-1:0]   r_reg;
    logic [3*Q-1:0]       q_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r_in[i]  = in_r[i*(W+1) +: W+1];
            ge[i]    = (r_in[i] >= {1'b0, in_n});
            r_dif[i] = ge[i] ? (r_in[i] - {1'b0, in_n}) : r_in[i];
            r_next[i*(W+1) +: W+1] = {r_dif[i][W-1:0], 1'b0};
            q_next[i*Q +: Q] = {in_q[i*Q +: Q-1], ge[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg   <= in_ctl;
            carry_reg <= in_carry;
            n_reg     <= in_n;
            r_reg     <= r_next;
            q_reg     <= q_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_carry = carry_reg;
    assign out_n     = n_reg;
    assign out_r     = r_reg;
    assign out_q     = q_reg;

endmodule

FILE: src/vector3_alu.sv
// Three-component vector unit in signed fixed point (WORD_BITS wide, FRAC_BITS fractional):
// add, sub, scale, dot, cross, norm, normalize, distance and equality, saturating results.
// One item enters every cycle while the pipeline is not frozen; each result passes through
// the operand select, multiply and sum registers, a square-root step for each root bit of
// the digit-by-digit square root, a divider step for each quotient bit of the normalize
// divider, and the output register. A stall on the result side while a result is valid
// freezes the whole pipeline and is passed straight back as item_stall.
module vector3_alu #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  v3alu_pkg::item_t    item,
    output logic                result_valid,
    input  logic                result_stall,
    output v3alu_pkg::result_t  result
);

    localparam int W   = WORD_BITS;
    localparam int Q   = FRAC_BITS + 1;
    localparam int CW1 = 7*W + 3;
    localparam int CW2 = 4*W + 3;
    localparam int LW  = W + FRAC_BITS + 2;
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    logic adv;

    logic            f_valid;
    v3alu_pkg::ctl_t f_ctl;
    logic [3*W-1:0]  f_rv;
    logic [W-1:0]    f_sv;
    logic [2*W-1:0]  f_ssq;
    logic [3*W-1:0]  f_aabs;
    logic [2:0]      f_aneg;

    logic            sq_valid [W+1];
    v3alu_pkg::ctl_t sq_ctl [W+1];
    logic [CW1-1:0]  sq_carry [W+1];
    logic [2*W-1:0]  sq_s [W+1];
    logic [W:0]      sq_rem [W+1];
    logic [W-1:0]    sq_root [W+1];

    logic               dv_valid [Q+1];
    v3alu_pkg::ctl_t    dv_ctl [Q+1];
    logic [CW2-1:0]     dv_carry [Q+1];
    logic [W-1:0]       dv_n [Q+1];
    logic [3*(W+1)-1:0] dv_r [Q+1];
    logic [3*Q-1:0]     dv_q [Q+1];

    logic [W-1:0]        root_n;
    logic [3:0]          mid_action;
    logic [W-1:0]        mid_sv;
    v3alu_pkg::ctl_t     mid_ctl;

    logic signed [LW-1:0] qv [3];
    logic signed [W-1:0]  nrm [3];
    logic signed [W-1:0]  rvec [3];
    logic signed [W-1:0]  fin_sv;
    v3alu_pkg::ctl_t      fin_ctl;
    logic [2:0]           fin_aneg;
    v3alu_pkg::result_t   result_next;

    logic                 result_valid_reg;
    v3alu_pkg::result_t   result_reg;

    assign adv        = !(result_valid_reg && result_stall);
    assign item_stall = !adv;

    v3alu_front #(
        .W (W),
        .F (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (item_valid),
        .in_data   (item),
        .out_valid (f_valid),
        .out_ctl   (f_ctl),
        .out_rv    (f_rv),
        .out_sv    (f_sv),
        .out_ssq   (f_ssq),
        .out_aabs  (f_aabs),
        .out_aneg  (f_aneg)
    );

    assign sq_valid[0] = f_valid;
    assign sq_ctl[0]   = f_ctl;
    assign sq_carry[0] = {f_aneg, f_aabs, f_sv, f_rv};
    assign sq_s[0]     = f_ssq;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;

    for (genvar g = 0; g < W; g++)
    begin : g_sqrt
        v3alu_sqrt_step #(
            .W  (W),
            .CW (CW1)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (sq_valid[g]),
            .in_ctl    (sq_ctl[g]),
            .in_carry  (sq_carry[g]),
            .in_s      (sq_s[g]),
            .in_rem    (sq_rem[g]),
            .in_root   (sq_root[g]),
            .out_valid (sq_valid[g+1]),
            .out_ctl   (sq_ctl[g+1]),
            .out_carry (sq_carry[g+1]),
            .out_s     (sq_s[g+1]),
            .out_rem   (sq_rem[g+1]),
            .out_root  (sq_root[g+1])
        );
    end

    assign root_n     = sq_root[W];
    assign mid_action = sq_ctl[W].action;

    always_comb
    begin
        mid_ctl = sq_ctl[W];
        mid_ctl.null_error = (mid_action == v3alu_pkg::ACT_NORMALIZE) && (root_n == '0);
        mid_sv = sq_carry[W][4*W-1:3*W];
        if ((mid_action == v3alu_pkg::ACT_NORM) || (mid_action == v3alu_pkg::ACT_DIST))
        begin
            mid_sv = root_n[W-1] ? WMAX : root_n;
        end
    end

    assign dv_valid[0] = sq_valid[W];
    assign dv_ctl[0]   = mid_ctl;
    assign dv_carry[0] = {sq_carry[W][7*W+2:7*W], mid_sv, sq_carry[W][3*W-1:0]};
    assign dv_n[0]     = root_n;
    assign dv_q[0]     = '0;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dv_r[0][i*(W+1) +: W+1] = {1'b0, sq_carry[W][4*W + i*W +: W]};
        end
    end

    for (genvar g = 0; g < Q; g++)
    begin : g_div
        v3alu_div_step #(
            .W  (W),
            .Q  (Q),
            .CW (CW2)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (dv_valid[g]),
            .in_ctl    (dv_ctl[g]),
            .in_carry  (dv_carry[g]),
            .in_n      (dv_n[g]),
            .in_r      (dv_r[g]),
            .in_q      (dv_q[g]),
            .out_valid (dv_valid[g+1]),
            .out_ctl   (dv_ctl[g+1]),
            .out_carry (dv_carry[g+1]),
            .out_n     (dv_n[g+1]),
            .out_r     (dv_r[g+1]),
            .out_q     (dv_q[g+1])
        );
    end

    assign fin_ctl  = dv_ctl[Q];
    assign fin_aneg = dv_carry[Q][4*W+2:4*W];
    assign fin_sv   = dv_carry[Q][4*W-1:3*W];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qv[i] = LW'(dv_q[Q][i*Q +: Q]);
            if (fin_aneg[i])
            begin
                qv[i] = -qv[i];
            end
            if (qv[i] > LW'(WMAX))
            begin
                nrm[i] = WMAX;
            end
            else if (qv[i] < LW'(WMIN))
            begin
                nrm[i] = WMIN;
            end
            else
            begin
                nrm[i] = qv[i][W-1:0];
            end
            if (fin_ctl.action == v3alu_pkg::ACT_NORMALIZE)
            begin
                rvec[i] = fin_ctl.null_error ? '0 : nrm[i];
            end
            else
            begin
                rvec[i] = dv_carry[Q][i*W +: W];
            end
        end
        result_next.rx         = 32'(rvec[0]);
        result_next.ry         = 32'(rvec[1]);
        result_next.rz         = 32'(rvec[2]);
        result_next.scalar_out = 32'(fin_sv);
        result_next.equal_flag = fin_ctl.equal_flag;
        result_next.null_error = fin_ctl.null_error;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= dv_valid[Q];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.null_error |->
            result.rx == 32'sd0 && result.ry == 32'sd0 && result.rz == 32'sd0)
        else $error("null_error with nonzero vector");

    a_equal_only: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.equal_flag |->
            result.rx == 32'sd0 && result.scalar_out == 32'sd0 && !result.null_error)
        else $error("equal_flag with other results");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> item_stall)
        else $error("item taken while pipeline frozen");

endmodule

FILE: test/tb.sv
module tb;

    localparam int LATENCY = 53;

    class vec_scoreboard;
        v3alu_pkg::result_t expected_q[$];
        int                 errors;

        function new();
            errors = 0;
        endfunction

        function automatic logic signed [31:0] clip(logic signed [127:0] v);
            if (v > 128'sh7fffffff)
                return 32'sh7fffffff;
            if (v < -128'sh80000000)
                return 32'sh80000000;
            return v[31:0];
        endfunction

        function automatic logic [63:0] root(logic [63:0] s);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > s)
                b >>= 2;
            while (b != 0)
            begin
                if (s >= r + b)
                begin
                    s -= r + b;
                    r = (r >> 1) + b;
                end
                else
                begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function automatic logic [63:0] length3(logic signed [127:0] x, logic signed [127:0] y,
                                                logic signed [127:0] z);
            logic signed [127:0] s;
            s = x * x + y * y + z * z;
            return root(s[63:0]);
        endfunction

        function automatic logic signed [31:0] norm_clip(logic [63:0] n);
            return (n > 64'h7fff_ffff) ? 32'sh7fffffff : n[31:0];
        endfunction

        function automatic v3alu_pkg::result_t predict(v3alu_pkg::item_t it);
            v3alu_pkg::result_t  r;
            logic signed [127:0] a_x, a_y, a_z, b_x, b_y, b_z, k, nn;
            logic signed [127:0] d_x, d_y, d_z;
            logic [63:0]         n;
            r = '0;
            a_x = it.ax;
            a_y = it.ay;
            a_z = it.az;
            b_x = it.bx;
            b_y = it.by;
            b_z = it.bz;
            k = it.scale;
            case (it.action)
                v3alu_pkg::ACT_ADD:
                begin
                    r.rx = clip(a_x + b_x);
                    r.ry = clip(a_y + b_y);
                    r.rz = clip(a_z + b_z);
                end
                v3alu_pkg::ACT_SUB:
                begin
                    r.rx = clip(a_x - b_x);
                    r.ry = clip(a_y - b_y);
                    r.rz = clip(a_z - b_z);
                end
                v3alu_pkg::ACT_SCALE:
                begin
                    r.rx = clip((a_x * k) >>> 16);
                    r.ry = clip((a_y * k) >>> 16);
                    r.rz = clip((a_z * k) >>> 16);
                end
                v3alu_pkg::ACT_DOT:
                    r.scalar_out = clip((a_x * b_x + a_y * b_y + a_z * b_z) >>> 16);
                v3alu_pkg::ACT_CROSS:
                begin
                    r.rx = clip((a_y * b_z - a_z * b_y) >>> 16);
                    r.ry = clip((a_z * b_x - a_x * b_z) >>> 16);
                    r.rz = clip((a_x * b_y - a_y * b_x) >>> 16);
                end
                v3alu_pkg::ACT_NORM:
                    r.scalar_out = norm_clip(length3(a_x, a_y, a_z));
                v3alu_pkg::ACT_NORMALIZE:
                begin
                    n = length3(a_x, a_y, a_z);
                    if (n == 0)
                    begin
                        r.null_error = 1'b1;
                    end
                    else
                    begin
                        nn = n;
                        r.rx = clip((a_x <<< 16) / nn);
                        r.ry = clip((a_y <<< 16) / nn);
                        r.rz = clip((a_z <<< 16) / nn);
                    end
                end
                v3alu_pkg::ACT_DIST:
                begin
                    d_x = clip(a_x - b_x);
                    d_y = clip(a_y - b_y);
                    d_z = clip(a_z - b_z);
                    r.scalar_out = norm_clip(length3(d_x, d_y, d_z));
                end
                v3alu_pkg::ACT_EQUAL:
                    r.equal_flag = (it.ax == it.bx && it.ay == it.by && it.az == it.bz);
                default:
                    r = '0;
            endcase
            return r;
        endfunction

        function void note_item(v3alu_pkg::item_t it);
            expected_q.push_back(predict(it));
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch: %s got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(v3alu_pkg::result_t got);
            v3alu_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                report("unexpected result transfer", 1, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.rx != want.rx)
                report("rx", got.rx, want.rx);
            if (got.ry != want.ry)
                report("ry", got.ry, want.ry);
            if (got.rz != want.rz)
                report("rz", got.rz, want.rz);
            if (got.scalar_out != want.scalar_out)
                report("scalar_out", got.scalar_out, want.scalar_out);
            if (got.equal_flag != want.equal_flag)
                report("equal_flag", got.equal_flag, want.equal_flag);
            if (got.null_error != want.null_error)
                report("null_error", got.null_error, want.null_error);
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    v3alu_pkg::item_t   item;
    logic               result_valid;
    logic               result_stall = 1'b0;
    v3alu_pkg::result_t result;

    vec_scoreboard sb;
    logic          no_idle;
    int            stall_left = 0;

    vector3_alu u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            sb.note_item(item);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            sb.check_result(result);
            stall_left = no_idle ? 0 : $urandom_range(0, 8);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 6))
            0, 1: return $urandom;
            2:    return $signed($urandom_range(0, 2 * 1048576)) - 1048576;
            3:    return 32'sh7fffffff;
            4:    return 32'sh80000000;
            5:    return 0;
            default: return $signed($urandom_range(0, 16)) - 8;
        endcase
    endfunction

    task send(v3alu_pkg::item_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    task send_vectors(logic [3:0] act, logic signed [31:0] x0, logic signed [31:0] y0,
                      logic signed [31:0] z0, logic signed [31:0] x1, logic signed [31:0] y1,
                      logic signed [31:0] z1, logic signed [31:0] k);
        v3alu_pkg::item_t it;
        it.action = act;
        it.ax = x0;
        it.ay = y0;
        it.az = z0;
        it.bx = x1;
        it.by = y1;
        it.bz = z1;
        it.scale = k;
        send(it);
    endtask

    localparam logic signed [31:0] WMAX = 32'sh7fffffff;
    localparam logic signed [31:0] WMIN = 32'sh80000000;

    initial
    begin
        v3alu_pkg::item_t it;
        int               waited;
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        no_idle = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int a = 0; a < 16; a++)
            send_vectors(4'(a), WMAX, WMIN, 0, WMIN, WMAX, -1, WMIN);
        send_vectors(v3alu_pkg::ACT_NORMALIZE, 0, 0, 0, 5, 5, 5, 0);
        send_vectors(v3alu_pkg::ACT_NORMALIZE, WMIN, WMIN, WMIN, 0, 0, 0, 0);
        send_vectors(v3alu_pkg::ACT_NORMALIZE, 0, 0, 1, 0, 0, 0, 0);
        send_vectors(v3alu_pkg::ACT_NORM, WMIN, WMIN, WMIN, 0, 0, 0, 0);
        send_vectors(v3alu_pkg::ACT_EQUAL, WMIN, 7, WMAX, WMIN, 7, WMAX, 0);
        send_vectors(v3alu_pkg::ACT_DIST, WMAX, WMAX, WMAX, WMIN, WMIN, WMIN, 0);
        send_vectors(v3alu_pkg::ACT_SCALE, WMIN, WMAX, 65536, 0, 0, 0, WMAX);
        send_vectors(v3alu_pkg::ACT_CROSS, WMIN, WMIN, WMIN, WMIN, WMAX, WMIN, 0);

        for (int i = 0; i < 1830; i++)
        begin
            if (i % 200 == 0)
                no_idle = ((i / 200) % 3 == 1);
            it.action = ($urandom_range(0, 19) == 0)
                      ? 4'($urandom_range(v3alu_pkg::ACT_EQUAL + 1, 15))
                      : 4'($urandom_range(0, v3alu_pkg::ACT_EQUAL));
            it.ax = pick_word();
            it.ay = pick_word();
            it.az = pick_word();
            it.bx = pick_word();
            it.by = pick_word();
            it.bz = pick_word();
            it.scale = pick_word();
            if (it.action == v3alu_pkg::ACT_EQUAL && $urandom_range(0, 1))
            begin
                it.bx = it.ax;
                it.by = it.ay;
                it.bz = ($urandom_range(0, 2) == 0) ? it.az ^ (32'sd1 << $urandom_range(0, 31))
                                                    : it.az;
            end
            if (it.action == v3alu_pkg::ACT_NORMALIZE && $urandom_range(0, 7) == 0)
            begin
                it.ax = 0;
                it.ay = 0;
                it.az = 0;
            end
            send(it);
        end
        item_valid <= 1'b0;

        waited = 0;
        while (sb.expected_q.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (2 * LATENCY) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
